>>> sv/plu_pkg.sv
// ---------------------------------------------------------------------------
// plu_pkg
// Shared constants for the palette lookup-or-insert unit.
// ---------------------------------------------------------------------------
package plu_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int IDX_W       = 8;
  localparam int RGB_W       = 24;
  localparam int DAC_W       = 6;

  localparam logic [IDX_W-1:0] IDX_BLACK = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_WHITE = IDX_W'(PAL_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_FREE = IDX_W'(PAL_ENTRIES - 2);

  localparam logic [RGB_W-1:0] RGB_BLACK = {RGB_W{1'b0}};
  localparam logic [RGB_W-1:0] RGB_WHITE = {RGB_W{1'b1}};

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [DAC_W-1:0] dac_t;

endpackage

>>> sv/plu_ram.sv
// ---------------------------------------------------------------------------
// plu_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module plu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/palette_lookup_or_insert_unit.sv
// ---------------------------------------------------------------------------
// palette_lookup_or_insert_unit
// Maps a 24-bit RGB colour to a palette index, inserting it on a miss.
// ---------------------------------------------------------------------------
// An item is accepted at a rising edge with start high and busy low. Black
// and white answer with their reserved indices in the cycle after
// acceptance and keep busy low. Any other colour starts a linear search
// through the palette RAM, one read per cycle over entries 1 to
// next_slot-1; the RAM's registered read port puts each compare in the
// cycle after its read. A hit ends the search at once; a miss writes the
// colour at next_slot and reports it as inserted with the 6-bit DAC
// values. The result appears for one cycle with strobe high. busy is high
// from acceptance until the cycle of the strobe.
// Reset empties the palette logically (next_slot returns to 1); the RAM
// itself is not cleared, as entries at or above next_slot are never
// compared. The receiver cannot hold results off, and none is needed: at
// most one item is in flight.
// ---------------------------------------------------------------------------
module palette_lookup_or_insert_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          color_red,
  input  logic [7:0]          color_green,
  input  logic [7:0]          color_blue,
  output logic                strobe,
  output plu_pkg::idx_t       color_index,
  output logic                inserted,
  output plu_pkg::dac_t       dac_red,
  output plu_pkg::dac_t       dac_green,
  output plu_pkg::dac_t       dac_blue
);
  import plu_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state;
  logic state_next;
  rgb_t rgb;
  idx_t rd_addr;
  idx_t cmp_addr;
  logic cmp_valid;
  idx_t next_slot;
  idx_t next_slot_next;
  rgb_t rd_data;
  rgb_t in_rgb;
  logic issuing;
  logic hit;
  logic miss;

  assign in_rgb  = {color_red, color_green, color_blue};
  assign busy    = (state == ST_SEARCH);
  assign issuing = (state == ST_SEARCH) && (rd_addr < next_slot);
  assign hit     = (state == ST_SEARCH) && cmp_valid && (rd_data == rgb);
  assign miss    = (state == ST_SEARCH) && !issuing && !hit;
  assign next_slot_next = (next_slot >= LAST_FREE) ? IDX_FIRST : next_slot + IDX_W'(1);

  // The write on a miss lands before the next item's first read, so the
  // read port never needs forwarding.
  plu_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PAL_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (miss),
    .waddr (next_slot),
    .wdata (rgb),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && in_rgb != RGB_BLACK && in_rgb != RGB_WHITE) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit || miss) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_slot <= IDX_FIRST;
      strobe    <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      strobe    <= 1'b0;
      cmp_valid <= issuing;
      if (miss) begin
        next_slot <= next_slot_next;
      end
      if (state == ST_IDLE && start &&
          (in_rgb == RGB_BLACK || in_rgb == RGB_WHITE)) begin
        strobe <= 1'b1;
      end
      if (hit || miss) begin
        strobe <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr <= rd_addr;
    if (state == ST_IDLE) begin
      rgb     <= in_rgb;
      rd_addr <= IDX_FIRST;
      if (in_rgb == RGB_BLACK) begin
        color_index <= IDX_BLACK;
      end else begin
        color_index <= IDX_WHITE;
      end
      inserted  <= 1'b0;
      dac_red   <= '0;
      dac_green <= '0;
      dac_blue  <= '0;
    end else begin
      if (issuing) begin
        rd_addr <= rd_addr + IDX_W'(1);
      end
      if (hit) begin
        color_index <= cmp_addr;
        inserted    <= 1'b0;
        dac_red     <= '0;
        dac_green   <= '0;
        dac_blue    <= '0;
      end else if (miss) begin
        color_index <= next_slot;
        inserted    <= 1'b1;
        dac_red     <= rgb[23:18];
        dac_green   <= rgb[15:10];
        dac_blue    <= rgb[7:2];
      end
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    next_slot != IDX_BLACK && next_slot <= LAST_FREE)
    else $error("next_slot left the free range");

  a_insert_index: assert property (@(posedge clk) disable iff (rst)
    (strobe && inserted) |-> color_index == $past(next_slot))
    else $error("inserted item not reported at the insertion slot");

  a_hit_dac_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !inserted) |-> (dac_red == '0 && dac_green == '0 && dac_blue == '0))
    else $error("DAC fields set on a result that was not inserted");

  a_black_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_rgb == RGB_BLACK) |=> (strobe && color_index == IDX_BLACK))
    else $error("black did not map to the reserved index");

  a_compare_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && cmp_valid) |-> cmp_addr < next_slot)
    else $error("compare beyond the filled part of the palette");

endmodule
